>>> rtl/core/lgs_pkg.sv
package lgs_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 64;

    localparam int WIDTH_REG_W  = 6;
    localparam int HEIGHT_REG_W = 7;

    localparam int BOARD_WIDTH_RESET  = 20;
    localparam int BOARD_HEIGHT_RESET = 20;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int HM1_W   = $clog2(MAX_HEIGHT);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 2);
    localparam int COUNT_W = 4;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BOARD_WIDTH  = CFG_INDEX_W'(0),
        REG_BOARD_HEIGHT = CFG_INDEX_W'(1)
    } cfg_reg_t;

    typedef struct packed {
        logic top_dead;
        logic bottom_dead;
        logic left_dead;
        logic right_dead;
        logic last_in_run;
        logic frame_end;
    } cell_info_t;

endpackage

>>> rtl/core/life_generation_stencil_unit.sv
// Streaming Life engine: cells of the current generation enter in raster order, one per
// cycle while s_ready is high; next-generation states leave in the same order. Two row
// buffers of one bit per column and a 3x3 window supply the neighborhood; cells outside
// the board count as dead. The result for a cell leaves after width+1 further cells have
// entered. It passes two register stages, window and output, before m_valid rises. The
// last cell of a frame starts a flush of width+1 dead cells through the same window
// pipeline, during which s_ready is low; the final result carries frame_end. A write to
// either board register restarts the frame, writes to other indexes are ignored, and the
// user must write configuration only while the block is idle; the block does not enforce it.
module life_generation_stencil_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cell_alive,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_next_alive,
    output logic                             m_last_in_run,
    output logic                             m_frame_end,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lgs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lgs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import lgs_pkg::*;

    logic [COL_W-1:0]      wm1_reg, wm1_next;
    logic [HM1_W-1:0]      hm1_reg, hm1_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic                  flush_reg, flush_next;

    logic [MAX_WIDTH-1:0]  store_top_reg;
    logic [MAX_WIDTH-1:0]  store_mid_reg;

    logic [2:0][2:0]       win_reg, win_next;
    cell_info_t            info_reg, info_next;
    logic                  s1_valid_reg, s1_valid_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_alive_reg, out_alive_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_end_reg, out_end_next;

    logic                  cfg_accept;
    logic                  cfg_restart;
    logic                  out_load;
    logic                  step_ready;
    logic                  in_accept;
    logic                  step;
    logic                  in_bit;
    logic                  top_bit;
    logic                  mid_bit;
    logic                  is_last_real;
    logic                  is_final;
    logic [COL_W-1:0]      kc;
    logic [ROW_W-1:0]      kr;
    logic                  centre_ok;
    logic [WIDTH_REG_W-1:0]  width_raw;
    logic [HEIGHT_REG_W-1:0] height_raw;
    logic [COUNT_W-1:0]    count;
    logic                  dead;

    assign cfg_ready   = 1'b1;
    assign cfg_accept  = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_accept &&
                         (cfg_index == REG_BOARD_WIDTH || cfg_index == REG_BOARD_HEIGHT);

    assign out_load   = !out_valid_reg || m_ready;
    assign step_ready = !s1_valid_reg || out_load;
    assign s_ready    = step_ready && !flush_reg;
    assign in_accept  = s_valid && s_ready;
    assign step       = in_accept || (flush_reg && step_ready);

    assign in_bit  = flush_reg ? 1'b0 : s_cell_alive;
    assign top_bit = store_top_reg[col_reg];
    assign mid_bit = store_mid_reg[col_reg];

    assign m_valid       = out_valid_reg;
    assign m_next_alive  = out_alive_reg;
    assign m_last_in_run = out_last_reg;
    assign m_frame_end   = out_end_reg;

    always_comb begin
        width_raw  = cfg_data[WIDTH_REG_W-1:0];
        height_raw = cfg_data[HEIGHT_REG_W-1:0];
        wm1_next   = wm1_reg;
        hm1_next   = hm1_reg;
        if (cfg_accept) begin
            case (cfg_index)
                REG_BOARD_WIDTH: begin
                    if (width_raw == '0) begin
                        wm1_next = '0;
                    end else if (width_raw > WIDTH_REG_W'(MAX_WIDTH)) begin
                        wm1_next = COL_W'(MAX_WIDTH - 1);
                    end else begin
                        wm1_next = COL_W'(width_raw - WIDTH_REG_W'(1));
                    end
                end
                REG_BOARD_HEIGHT: begin
                    if (height_raw == '0) begin
                        hm1_next = '0;
                    end else if (height_raw > HEIGHT_REG_W'(MAX_HEIGHT)) begin
                        hm1_next = HM1_W'(MAX_HEIGHT - 1);
                    end else begin
                        hm1_next = HM1_W'(height_raw - HEIGHT_REG_W'(1));
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        is_last_real = !flush_reg && (row_reg == ROW_W'(hm1_reg)) && (col_reg == wm1_reg);
        is_final     = flush_reg && (row_reg == ROW_W'(hm1_reg) + ROW_W'(2));

        if (col_reg == '0) begin
            kc        = wm1_reg;
            kr        = row_reg - ROW_W'(2);
            centre_ok = row_reg >= ROW_W'(2);
        end else begin
            kc        = col_reg - COL_W'(1);
            kr        = row_reg - ROW_W'(1);
            centre_ok = row_reg >= ROW_W'(1);
        end

        col_next   = col_reg;
        row_next   = row_reg;
        flush_next = flush_reg;
        if (cfg_restart) begin
            col_next   = '0;
            row_next   = '0;
            flush_next = 1'b0;
        end else if (step) begin
            if (is_final) begin
                col_next   = '0;
                row_next   = '0;
                flush_next = 1'b0;
            end else begin
                if (col_reg == wm1_reg) begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
                if (is_last_real) begin
                    flush_next = 1'b1;
                end
            end
        end

        win_next      = win_reg;
        info_next     = info_reg;
        s1_valid_next = s1_valid_reg;
        if (step) begin
            win_next[0]           = win_reg[1];
            win_next[1]           = win_reg[2];
            win_next[2]           = {in_bit, mid_bit, top_bit};
            info_next.top_dead    = (kr == '0);
            info_next.bottom_dead = (kr == ROW_W'(hm1_reg));
            info_next.left_dead   = (kc == '0);
            info_next.right_dead  = (kc == wm1_reg);
            info_next.last_in_run = is_final || !(flush_reg || is_last_real);
            info_next.frame_end   = is_final;
            s1_valid_next         = centre_ok;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        count = '0;
        dead  = 1'b0;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                dead = (i == 0 && info_reg.top_dead) || (i == 2 && info_reg.bottom_dead) ||
                       (j == 0 && info_reg.left_dead) || (j == 2 && info_reg.right_dead);
                if (!(i == 1 && j == 1) && !dead) begin
                    count = count + COUNT_W'(win_reg[j][i]);
                end
            end
        end

        out_valid_next = out_valid_reg;
        out_alive_next = out_alive_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;
        if (out_load) begin
            out_valid_next = s1_valid_reg;
            out_alive_next = (count == COUNT_W'(3)) ||
                             (win_reg[1][1] && (count == COUNT_W'(2)));
            out_last_next  = info_reg.last_in_run;
            out_end_next   = info_reg.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            store_mid_reg[col_reg] <= in_bit;
            store_top_reg[col_reg] <= mid_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm1_reg       <= COL_W'(BOARD_WIDTH_RESET - 1);
            hm1_reg       <= HM1_W'(BOARD_HEIGHT_RESET - 1);
            col_reg       <= '0;
            row_reg       <= '0;
            flush_reg     <= 1'b0;
            win_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wm1_reg       <= wm1_next;
            hm1_reg       <= hm1_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            flush_reg     <= flush_next;
            win_reg       <= win_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        info_reg      <= info_next;
        out_alive_reg <= out_alive_next;
        out_last_reg  <= out_last_next;
        out_end_reg   <= out_end_next;
    end

endmodule
